>>> rtl/core/tsv_pkg.sv
package tsv_pkg;

	localparam int MAX_DIM     = 64;
	localparam int FRAC_BITS   = 8;
	localparam int DIM_W       = $clog2(MAX_DIM);
	localparam int ADDR_W      = 3 * DIM_W;
	localparam int STORE_DEPTH = 1 << ADDR_W;
	localparam int CTERM_W     = 2 * DIM_W;
	localparam int PTERM_W     = 3 * DIM_W;
	localparam int RC_W        = 2 * DIM_W + 1;
	localparam int SIZE_W      = 7;
	localparam int VOXEL_W     = 8;
	localparam int VOXEL_MAX   = 255;
	localparam int COORD_W     = 16;
	localparam int BASE_W      = COORD_W - FRAC_BITS + 2;
	localparam int WEIGHT_W    = FRAC_BITS + 1;
	localparam int INDEX_W     = 18;

	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;

	localparam int S_FIELDS_W  = INDEX_W + VOXEL_W + 3 * COORD_W;
	localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_TDATA_W   = VOXEL_W;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int NBR_COUNT   = 8;
	localparam int NBR_W       = $clog2(NBR_COUNT);

	localparam int A_W         = VOXEL_W + FRAC_BITS + 4;
	localparam int B_W         = A_W + FRAC_BITS + 2;
	localparam int T_W         = B_W + FRAC_BITS + 2;
	localparam logic [T_W-1:0] T_MAX = T_W'(VOXEL_MAX) << (3 * FRAC_BITS);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SIZE_ROWS   = 2'd0,
		CFG_SIZE_COLS   = 2'd1,
		CFG_SIZE_PLANES = 2'd2,
		CFG_BAD_VALUE   = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_LOAD    = 2'd0,
		KIND_SAMPLE  = 2'd1,
		KIND_OUTSIDE = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                      kind;
		logic [ADDR_W-1:0]          addr;
		logic [VOXEL_W-1:0]         value;
		logic [DIM_W-1:0]           r0;
		logic [DIM_W-1:0]           r1;
		logic [CTERM_W-1:0]         ct0;
		logic [CTERM_W-1:0]         ct1;
		logic [PTERM_W-1:0]         pt0;
		logic [PTERM_W-1:0]         pt1;
		logic signed [WEIGHT_W-1:0] wr;
		logic signed [WEIGHT_W-1:0] wc;
		logic signed [WEIGHT_W-1:0] wp;
	} cmd_t;

endpackage

>>> rtl/core/tsv_front.sv
module tsv_front import tsv_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      mode,
	input  logic [INDEX_W-1:0]        voxel_index,
	input  logic [VOXEL_W-1:0]        voxel_value,
	input  logic signed [COORD_W-1:0] coord_row,
	input  logic signed [COORD_W-1:0] coord_col,
	input  logic signed [COORD_W-1:0] coord_plane,
	output logic                      push_valid,
	input  logic                      push_ready,
	output cmd_t                      push_cmd,
	output logic [VOXEL_W-1:0]        bad_value
);

	typedef struct packed {
		logic                       ok;
		logic [DIM_W-1:0]           lo;
		logic [DIM_W-1:0]           hi;
		logic signed [WEIGHT_W-1:0] w;
	} split_t;

	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
		return (s > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : s;
	endfunction

	function automatic split_t axis_split(input logic signed [COORD_W-1:0] coord,
			input logic [SIZE_W-1:0] size);
		logic signed [COORD_W:0]   p;
		logic                      neg_frac;
		logic signed [BASE_W-1:0]  b;
		logic signed [BASE_W-1:0]  u;
		logic signed [BASE_W-1:0]  lo;
		logic signed [BASE_W-1:0]  hi;
		logic signed [BASE_W-1:0]  sz;
		logic signed [COORD_W:0]   p_int;
		split_t                    r;
		p        = {coord[COORD_W-1], coord} - (COORD_W+1)'(1 << FRAC_BITS);
		neg_frac = p[COORD_W] & (|p[FRAC_BITS-1:0]);
		p_int    = p >>> FRAC_BITS;
		b        = p_int[BASE_W-1:0] + BASE_W'(neg_frac);
		u        = b + BASE_W'(1);
		sz       = BASE_W'(size);
		lo       = (b == {BASE_W{1'b1}}) ? '0 : b;
		hi       = (u == sz) ? sz - BASE_W'(1) : u;
		r.ok     = !lo[BASE_W-1] && !hi[BASE_W-1] && (hi < sz);
		r.lo     = lo[DIM_W-1:0];
		r.hi     = hi[DIM_W-1:0];
		r.w      = {neg_frac, p[FRAC_BITS-1:0]};
		return r;
	endfunction

	logic [SIZE_W-1:0]  size_rows_q, size_cols_q, size_planes_q;
	logic [VOXEL_W-1:0] bad_value_q;
	logic [RC_W-1:0]    rc_q;
	logic [SIZE_W-1:0]  eff_rows, eff_cols, eff_planes;
	logic [2*SIZE_W-1:0] rc_full;

	logic                      valid_s1;
	logic                      mode_s1;
	logic [INDEX_W-1:0]        index_s1;
	logic [VOXEL_W-1:0]        value_s1;
	logic signed [COORD_W-1:0] row_s1, col_s1, plane_s1;

	logic valid_s2;
	cmd_t cmd_s2;
	cmd_t cmd_d;
	logic adv_s2;

	split_t sr, sc, sp;
	logic [DIM_W+SIZE_W-1:0] ct0_full, ct1_full;
	logic [DIM_W+RC_W-1:0]   pt0_full, pt1_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_rows_q   <= SIZE_W'(MAX_DIM);
			size_cols_q   <= SIZE_W'(MAX_DIM);
			size_planes_q <= SIZE_W'(MAX_DIM);
			bad_value_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_SIZE_ROWS:   size_rows_q   <= cfg_data[SIZE_W-1:0];
				CFG_SIZE_COLS:   size_cols_q   <= cfg_data[SIZE_W-1:0];
				CFG_SIZE_PLANES: size_planes_q <= cfg_data[SIZE_W-1:0];
				CFG_BAD_VALUE:   bad_value_q   <= cfg_data[VOXEL_W-1:0];
			endcase
		end
	end

	assign eff_rows   = eff_size(size_rows_q);
	assign eff_cols   = eff_size(size_cols_q);
	assign eff_planes = eff_size(size_planes_q);
	assign rc_full    = eff_rows * eff_cols;
	assign bad_value  = bad_value_q;

	always_ff @(posedge clk) begin
		rc_q <= rc_full[RC_W-1:0];
	end

	assign adv_s2   = !valid_s2 || push_ready;
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1  <= mode;
			index_s1 <= voxel_index;
			value_s1 <= voxel_value;
			row_s1   <= coord_row;
			col_s1   <= coord_col;
			plane_s1 <= coord_plane;
		end
		if (adv_s2 && valid_s1)
			cmd_s2 <= cmd_d;
	end

	always_comb begin
		sr       = axis_split(row_s1, eff_rows);
		sc       = axis_split(col_s1, eff_cols);
		sp       = axis_split(plane_s1, eff_planes);
		ct0_full = sc.lo * eff_rows;
		ct1_full = sc.hi * eff_rows;
		pt0_full = sp.lo * rc_q;
		pt1_full = sp.hi * rc_q;

		cmd_d       = '0;
		cmd_d.addr  = index_s1[ADDR_W-1:0];
		cmd_d.value = value_s1;
		cmd_d.r0    = sr.lo;
		cmd_d.r1    = sr.hi;
		cmd_d.ct0   = ct0_full[CTERM_W-1:0];
		cmd_d.ct1   = ct1_full[CTERM_W-1:0];
		cmd_d.pt0   = pt0_full[PTERM_W-1:0];
		cmd_d.pt1   = pt1_full[PTERM_W-1:0];
		cmd_d.wr    = sr.w;
		cmd_d.wc    = sc.w;
		cmd_d.wp    = sp.w;
		if (!mode_s1)
			cmd_d.kind = KIND_LOAD;
		else if (sr.ok && sc.ok && sp.ok)
			cmd_d.kind = KIND_SAMPLE;
		else
			cmd_d.kind = KIND_OUTSIDE;
	end

	assign push_valid = valid_s2;
	assign push_cmd   = cmd_s2;

endmodule

>>> rtl/core/tsv_fifo.sv
module tsv_fifo import tsv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	cmd_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push, do_pop;

	assign push_ready = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_cmd    = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + (QPTR_W+1)'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - (QPTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			entries_q[wr_ptr_q] <= push_cmd;
	end

endmodule

>>> rtl/core/tsv_back.sv
module tsv_back import tsv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_pop,
	input  cmd_t               cmd,
	input  logic [VOXEL_W-1:0] bad_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [VOXEL_W-1:0] out_value,
	output logic               out_flag
);

	typedef enum logic {ST_IDLE, ST_ISSUE} state_t;

	function automatic logic [ADDR_W-1:0] voxel_addr(input cmd_t c, input logic [NBR_W-1:0] k);
		logic [ADDR_W-1:0] r, ct, pt;
		r  = ADDR_W'(k[0] ? c.r1 : c.r0);
		ct = ADDR_W'(k[1] ? c.ct1 : c.ct0);
		pt = ADDR_W'(k[2] ? c.pt1 : c.pt0);
		return r + ct + pt;
	endfunction

	logic [VOXEL_W-1:0] store [STORE_DEPTH];

	state_t            state_q;
	logic [NBR_W-1:0]  cnt_q;
	cmd_t              cur_q;

	logic              out_valid_q;
	logic [VOXEL_W-1:0] out_value_q;
	logic              out_flag_q;

	logic              out_free, hold, pipe_empty;
	logic              iss_valid, out_outside, mem_we, mem_re;
	logic [NBR_W-1:0]  iss_tag;
	cmd_t              iss_cmd;
	logic [ADDR_W-1:0] mem_addr;

	logic                       valid_s1;
	logic [NBR_W-1:0]           tag_s1;
	logic signed [WEIGHT_W-1:0] wr_s1, wc_s1, wp_s1;
	logic [VOXEL_W-1:0]         data_s1;
	logic [VOXEL_W-1:0]         lo_q;

	logic                       valid_s2;
	logic [1:0]                 tag_s2;
	logic signed [WEIGHT_W-1:0] wc_s2, wp_s2;
	logic signed [A_W-1:0]      a_s2;
	logic signed [A_W-1:0]      a0_q;

	logic                       valid_s3;
	logic                       tag_s3;
	logic signed [WEIGHT_W-1:0] wp_s3;
	logic signed [B_W-1:0]      b_s3;
	logic signed [B_W-1:0]      b0_q;

	logic                       valid_s4;
	logic signed [T_W-1:0]      t_s4;

	logic signed [VOXEL_W+1:0]  diff_a;
	logic signed [A_W-1:0]      base_a, prod_a, a_next;
	logic signed [A_W:0]        diff_b;
	logic signed [B_W-1:0]      base_b, prod_b, b_next;
	logic signed [B_W:0]        diff_t;
	logic signed [T_W-1:0]      base_t, prod_t, t_next;
	logic [VOXEL_W-1:0]         clamp_value;

	assign out_free   = !out_valid_q || out_ready;
	assign hold       = valid_s4 && !out_free;
	assign pipe_empty = (state_q == ST_IDLE) && !valid_s1 && !valid_s2 && !valid_s3 && !valid_s4;

	always_comb begin
		cmd_pop     = 1'b0;
		iss_valid   = 1'b0;
		iss_tag     = cnt_q;
		iss_cmd     = cur_q;
		mem_we      = 1'b0;
		out_outside = 1'b0;
		if (!hold) begin
			if (state_q == ST_ISSUE) begin
				iss_valid = 1'b1;
			end else if (cmd_valid) begin
				unique case (cmd.kind)
					KIND_LOAD: begin
						cmd_pop = 1'b1;
						mem_we  = 1'b1;
					end
					KIND_SAMPLE: begin
						cmd_pop   = 1'b1;
						iss_valid = 1'b1;
						iss_tag   = '0;
						iss_cmd   = cmd;
					end
					KIND_OUTSIDE: begin
						if (pipe_empty && out_free) begin
							cmd_pop     = 1'b1;
							out_outside = 1'b1;
						end
					end
					default: begin
						cmd_pop = 1'b1;
					end
				endcase
			end
		end
		mem_re   = iss_valid;
		mem_addr = mem_we ? cmd.addr : voxel_addr(iss_cmd, iss_tag);
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			store[mem_addr] <= cmd.value;
		if (mem_re)
			data_s1 <= store[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else if (!hold) begin
			unique case (state_q)
				ST_IDLE: begin
					if (iss_valid) begin
						state_q <= ST_ISSUE;
						cnt_q   <= NBR_W'(1);
					end
				end
				ST_ISSUE: begin
					cnt_q <= cnt_q + NBR_W'(1);
					if (cnt_q == NBR_W'(NBR_COUNT - 1))
						state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && iss_valid)
			cur_q <= cmd;
	end

	always_comb begin
		diff_a = $signed({2'b00, data_s1}) - $signed({2'b00, lo_q});
		base_a = $signed({{(A_W-VOXEL_W-FRAC_BITS){1'b0}}, lo_q, {FRAC_BITS{1'b0}}});
		prod_a = wr_s1 * diff_a;
		a_next = base_a + prod_a;

		diff_b = {a_s2[A_W-1], a_s2} - {a0_q[A_W-1], a0_q};
		base_b = {{(B_W-A_W-FRAC_BITS){a0_q[A_W-1]}}, a0_q, {FRAC_BITS{1'b0}}};
		prod_b = wc_s2 * diff_b;
		b_next = base_b + prod_b;

		diff_t = {b_s3[B_W-1], b_s3} - {b0_q[B_W-1], b0_q};
		base_t = {{(T_W-B_W-FRAC_BITS){b0_q[B_W-1]}}, b0_q, {FRAC_BITS{1'b0}}};
		prod_t = wp_s3 * diff_t;
		t_next = base_t + prod_t;

		if (t_s4[T_W-1])
			clamp_value = '0;
		else if (t_s4 > $signed(T_MAX))
			clamp_value = VOXEL_W'(VOXEL_MAX);
		else
			clamp_value = t_s4[3*FRAC_BITS +: VOXEL_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (!hold) begin
			valid_s1 <= iss_valid;
			valid_s2 <= valid_s1 && tag_s1[0];
			valid_s3 <= valid_s2 && tag_s2[0];
			valid_s4 <= valid_s3 && tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold) begin
			if (iss_valid) begin
				tag_s1 <= iss_tag;
				wr_s1  <= iss_cmd.wr;
				wc_s1  <= iss_cmd.wc;
				wp_s1  <= iss_cmd.wp;
			end
			if (valid_s1) begin
				if (!tag_s1[0]) begin
					lo_q <= data_s1;
				end else begin
					a_s2   <= a_next;
					tag_s2 <= tag_s1[2:1];
					wc_s2  <= wc_s1;
					wp_s2  <= wp_s1;
				end
			end
			if (valid_s2) begin
				if (!tag_s2[0]) begin
					a0_q <= a_s2;
				end else begin
					b_s3   <= b_next;
					tag_s3 <= tag_s2[1];
					wp_s3  <= wp_s2;
				end
			end
			if (valid_s3) begin
				if (!tag_s3)
					b0_q <= b_s3;
				else
					t_s4 <= t_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if ((valid_s4 && !hold) || out_outside)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_outside) begin
			out_value_q <= bad_value;
			out_flag_q  <= 1'b1;
		end else if (valid_s4 && !hold) begin
			out_value_q <= clamp_value;
			out_flag_q  <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_flag  = out_flag_q;

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("store written and read in the same cycle");

	a_outside_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && cmd.kind == KIND_OUTSIDE) |-> (pipe_empty && out_free))
		else $error("outside result overtakes an interpolation in flight");

	a_hold_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		hold |=> (valid_s4 && $stable(t_s4)))
		else $error("final lerp result lost while output stalled");

	a_issue_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |-> (cnt_q != '0))
		else $error("neighbor counter out of step with issue state");

endmodule

>>> rtl/core/trilinear_sample_uint8_volume.sv
// Trilinear sampler over an 8-bit voxel volume of up to 64 x 64 x 64 entries.
// s_axis carries one item per transaction; tuser = 0 loads voxel_value at
// voxel_index, tuser = 1 requests a sample at a 1-based signed Q8.8 triple.
// m_axis returns one transaction per sample: tdata = interpolated byte, or
// bad_value with tuser = 1 when the point lies outside the volume. Loads
// return nothing. Results leave in the order the items came in.
// cfg_we/cfg_index/cfg_data write the three extents and bad_value; write them
// only while no item is in flight.
// A sample outside the volume is answered only after earlier samples have left
// the interpolation pipe. Loads go one per cycle while no sample issues and
// the output does not stall. The single store port reads one of the eight
// neighbors each cycle unless the output stalls, then takes the next sample.
// Reset: extents return to 64, bad_value to 0; store contents are undefined
// until loaded and no clearing pass runs.
// A stalled m_axis holds the output register and freezes the interpolation
// pipe; the 4-entry command queue then fills and s_axis_tready drops.
module trilinear_sample_uint8_volume import tsv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// voxel_index[17:0], voxel_value[25:18], coord_row[41:26],
	// coord_col[57:42], coord_plane[73:58], zero pad above
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,
	// mode[0]
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// sample_value[7:0]
	output logic [M_TDATA_W-1:0]  m_axis_tdata,
	// outside_flag[0]
	output logic                  m_axis_tuser
);

	localparam int VALUE_LSB = INDEX_W;
	localparam int ROW_LSB   = VALUE_LSB + VOXEL_W;
	localparam int COL_LSB   = ROW_LSB + COORD_W;
	localparam int PLANE_LSB = COL_LSB + COORD_W;

	logic               push_valid, push_ready, pop_valid, pop_ready;
	cmd_t               push_cmd, pop_cmd;
	logic [VOXEL_W-1:0] bad_value;

	tsv_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.mode        (s_axis_tuser),
		.voxel_index (s_axis_tdata[INDEX_W-1:0]),
		.voxel_value (s_axis_tdata[VALUE_LSB +: VOXEL_W]),
		.coord_row   ($signed(s_axis_tdata[ROW_LSB +: COORD_W])),
		.coord_col   ($signed(s_axis_tdata[COL_LSB +: COORD_W])),
		.coord_plane ($signed(s_axis_tdata[PLANE_LSB +: COORD_W])),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_cmd    (push_cmd),
		.bad_value   (bad_value)
	);

	tsv_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	tsv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd_pop   (pop_ready),
		.cmd       (pop_cmd),
		.bad_value (bad_value),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_value (m_axis_tdata),
		.out_flag  (m_axis_tuser)
	);

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import tsv_pkg::*;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef enum logic {MODE_LOAD = 1'b0, MODE_SAMPLE = 1'b1} mode_t;

	typedef struct packed {
		logic [VOXEL_W-1:0] value;
		logic               outside;
	} sample_t;

	typedef struct packed {
		mode_t              mode;
		logic [INDEX_W-1:0] index;
		logic [VOXEL_W-1:0] voxel;
		coord_t             row;
		coord_t             col;
		coord_t             plane;
		logic               typed;
		sample_t            want;
	} probe_t;

	localparam int UNIT          = 1 << FRAC_BITS;
	localparam int SETTLE_CYCLES = 32;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 320;
	localparam int SWAP_IDLE_AT  = 650;
	localparam int STOP_IDLE_AT  = 1300;
	localparam int PROBES        = 22;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic                  m_axis_tuser;

	logic [VOXEL_W-1:0] voxel_copy [STORE_DEPTH];
	bit                 voxel_loaded [STORE_DEPTH];
	logic [SIZE_W-1:0]  rows_reg   = 7'd64;
	logic [SIZE_W-1:0]  cols_reg   = 7'd64;
	logic [SIZE_W-1:0]  planes_reg = 7'd64;
	logic [VOXEL_W-1:0] bad_reg    = 8'd0;

	sample_t expected_samples [$];
	int      mismatch_count = 0;
	int      items_sent     = 0;
	int      src_gap_pct    = 19;
	int      sink_stall_pct = 87;

	probe_t probes [PROBES] = '{
		'{MODE_LOAD,   18'd0,      8'd0,   16'sd0,     16'sd0,     16'sd0,     1'b0, '{8'd0, 1'b0}},
		'{MODE_LOAD,   18'd262143, 8'd255, 16'sd0,     16'sd0,     16'sd0,     1'b0, '{8'd0, 1'b0}},
		'{MODE_LOAD,   18'h2AAAA,  8'hAA,  16'sd0,     16'sd0,     16'sd0,     1'b0, '{8'd0, 1'b0}},
		'{MODE_LOAD,   18'h15555,  8'h55,  16'sd0,     16'sd0,     16'sd0,     1'b0, '{8'd0, 1'b0}},
		'{MODE_SAMPLE, 18'd0,      8'd0,   16'sd256,   16'sd256,   16'sd256,   1'b0, '{8'd0, 1'b0}},
		'{MODE_SAMPLE, 18'd0,      8'd0,   16'sd16384, 16'sd16384, 16'sd16384, 1'b1,
			'{8'd255, 1'b0}},
		'{MODE_SAMPLE, 18'd0,      8'd0,   16'sd0,     16'sd0,     16'sd0,     1'b0, '{8'd0, 1'b0}},
		'{MODE_SAMPLE, 18'd0,      8'd0,   16'sd128,   16'sd128,   16'sd128,   1'b0, '{8'd0, 1'b0}},
		'{MODE_SAMPLE, 18'd0,      8'd0,   16'sd1,     16'sd1,     16'sd1,     1'b0, '{8'd0, 1'b0}},
		'{MODE_SAMPLE, 18'd0,      8'd0,   -16'sd1,    -16'sd1,    -16'sd1,    1'b0, '{8'd0, 1'b0}},
		'{MODE_SAMPLE, 18'd0,      8'd0,   -16'sd255,  -16'sd255,  -16'sd255,  1'b0, '{8'd0, 1'b0}},
		'{MODE_SAMPLE, 18'd0,      8'd0,   16'sd16639, 16'sd16639, 16'sd16639, 1'b0, '{8'd0, 1'b0}},
		'{MODE_SAMPLE, 18'd0,      8'd0,   16'sd16383, 16'sd16383, 16'sd16383, 1'b0, '{8'd0, 1'b0}},
		'{MODE_SAMPLE, 18'd0,      8'd0,   16'sd300,   16'sd5000,  16'sd12000, 1'b0, '{8'd0, 1'b0}},
		'{MODE_SAMPLE, 18'd0,      8'd0,   -16'sd256,  16'sd256,   16'sd256,   1'b1, '{8'd0, 1'b1}},
		'{MODE_SAMPLE, 18'd0,      8'd0,   16'sh8000,  16'sh8000,  16'sh8000,  1'b1, '{8'd0, 1'b1}},
		'{MODE_SAMPLE, 18'd0,      8'd0,   16'sh7FFF,  16'sh7FFF,  16'sh7FFF,  1'b1, '{8'd0, 1'b1}},
		'{MODE_SAMPLE, 18'd0,      8'd0,   16'sd256,   16'sd16640, 16'sd256,   1'b1, '{8'd0, 1'b1}},
		'{MODE_SAMPLE, 18'd0,      8'd0,   16'sd256,   16'sd256,   -16'sd257,  1'b1, '{8'd0, 1'b1}},
		'{MODE_LOAD,   18'd0,      8'd255, 16'sd0,     16'sd0,     16'sd0,     1'b0, '{8'd0, 1'b0}},
		'{MODE_SAMPLE, 18'd0,      8'd0,   16'sd256,   16'sd256,   16'sd256,   1'b0, '{8'd0, 1'b0}},
		'{MODE_SAMPLE, 18'd0,      8'd0,   16'sd128,   16'sd384,   -16'sd100,  1'b0, '{8'd0, 1'b0}}
	};

	logic [7:0] geometry_plan [PHASES][4] = '{
		'{8'd1,  8'd1,  8'd1,  8'hFF},
		'{8'd64, 8'd64, 8'd64, 8'h00},
		'{8'd2,  8'd3,  8'd5,  8'h5A},
		'{8'd0,  8'd4,  8'd4,  8'hA5},
		'{8'hC1, 8'd7,  8'd64, 8'h3C},
		'{8'd13, 8'd64, 8'd2,  8'h01}
	};

	trilinear_sample_uint8_volume dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #4 clk = ~clk;

	function automatic int extent(input logic [SIZE_W-1:0] s);
		return (s > MAX_DIM) ? MAX_DIM : int'(s);
	endfunction

	function automatic int voxel_addr(input int r, input int c, input int p);
		return r + c * extent(rows_reg) + p * extent(rows_reg) * extent(cols_reg);
	endfunction

	function automatic longint voxel_at(input int r, input int c, input int p);
		return longint'(voxel_copy[voxel_addr(r, c, p)]);
	endfunction

	// drop one unit, truncate toward zero, clamp the edges
	function automatic bit split_axis(input coord_t coord, input int n,
			output int lo, output int hi, output longint w);
		int p;
		int b;
		int u;
		p = int'(coord) - UNIT;
		b = p / UNIT;
		w = longint'(p - b * UNIT);
		u = b + 1;
		if (b == -1)
			b = 0;
		if (u == n)
			u = n - 1;
		lo = b;
		hi = u;
		return !(b < 0 || u < 0 || u >= n);
	endfunction

	function automatic longint blend(input longint a, input longint b, input longint w);
		return a * UNIT + w * (b - a);
	endfunction

	function automatic sample_t interp_sample(input coord_t cr, input coord_t cc,
			input coord_t cp);
		int     r0, r1, c0, c1, p0, p1;
		longint wr, wc, wp, a00, a01, a10, a11, b0, b1, t, full;
		bit     in_vol;
		sample_t res;
		full   = longint'(UNIT) * UNIT * UNIT;
		in_vol = split_axis(cr, extent(rows_reg), r0, r1, wr);
		in_vol = split_axis(cc, extent(cols_reg), c0, c1, wc) && in_vol;
		in_vol = split_axis(cp, extent(planes_reg), p0, p1, wp) && in_vol;
		if (!in_vol) begin
			res.value   = bad_reg;
			res.outside = 1'b1;
			return res;
		end
		a00 = blend(voxel_at(r0, c0, p0), voxel_at(r1, c0, p0), wr);
		a01 = blend(voxel_at(r0, c0, p1), voxel_at(r1, c0, p1), wr);
		a10 = blend(voxel_at(r0, c1, p0), voxel_at(r1, c1, p0), wr);
		a11 = blend(voxel_at(r0, c1, p1), voxel_at(r1, c1, p1), wr);
		b0  = blend(a00, a10, wc);
		b1  = blend(a01, a11, wc);
		t   = blend(b0, b1, wp);
		res.outside = 1'b0;
		if (t < 0)
			res.value = '0;
		else if (t > longint'(VOXEL_MAX) * full)
			res.value = VOXEL_W'(VOXEL_MAX);
		else
			res.value = VOXEL_W'(t / full);
		return res;
	endfunction

	function automatic coord_t pick_coord(input int n);
		int v;
		if ($urandom_range(0, 9) == 0)
			return coord_t'($urandom());
		v = int'($urandom_range(0, n * UNIT + 600)) - 300;
		return coord_t'(v);
	endfunction

	task automatic flag_mismatch(input string what);
		$display("[%0t] MISMATCH %s", $time, what);
		mismatch_count++;
	endtask

	task automatic push_item(input mode_t mode, input logic [INDEX_W-1:0] idx,
			input logic [VOXEL_W-1:0] val, input coord_t cr, input coord_t cc,
			input coord_t cp, input bit typed, input sample_t typed_result);
		if (items_sent < SWAP_IDLE_AT) begin
			src_gap_pct    = 19;
			sink_stall_pct = 87;
		end else if (items_sent < STOP_IDLE_AT) begin
			src_gap_pct    = 87;
			sink_stall_pct = 19;
		end else begin
			src_gap_pct    = 0;
			sink_stall_pct = 0;
		end
		while ($urandom_range(0, 99) < src_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= S_TDATA_W'({cp, cc, cr, val, idx});
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		if (mode == MODE_LOAD) begin
			voxel_copy[idx]   = val;
			voxel_loaded[idx] = 1'b1;
		end else begin
			expected_samples.push_back(typed ? typed_result : interp_sample(cr, cc, cp));
		end
	endtask

	// load every neighbor that the sample will read and that holds nothing yet
	task automatic request_sample(input coord_t cr, input coord_t cc, input coord_t cp,
			input bit typed, input sample_t typed_result);
		int     r0, r1, c0, c1, p0, p1, idx;
		longint wr, wc, wp;
		bit     in_vol;
		in_vol = split_axis(cr, extent(rows_reg), r0, r1, wr);
		in_vol = split_axis(cc, extent(cols_reg), c0, c1, wc) && in_vol;
		in_vol = split_axis(cp, extent(planes_reg), p0, p1, wp) && in_vol;
		if (in_vol) begin
			for (int k = 0; k < 8; k++) begin
				idx = voxel_addr(k[0] ? r1 : r0, k[1] ? c1 : c0, k[2] ? p1 : p0);
				if (!voxel_loaded[idx])
					push_item(MODE_LOAD, INDEX_W'(idx), VOXEL_W'($urandom()),
						coord_t'($urandom()), coord_t'($urandom()),
						coord_t'($urandom()), 1'b0, '0);
			end
		end
		push_item(MODE_SAMPLE, INDEX_W'($urandom()), VOXEL_W'($urandom()), cr, cc, cp,
			typed, typed_result);
	endtask

	// hold the input until every sample has returned, then let loads drain
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] vals [4]);
		cfg_reg_t regs [4];
		regs = '{CFG_SIZE_ROWS, CFG_SIZE_COLS, CFG_SIZE_PLANES, CFG_BAD_VALUE};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		cfg_we     <= 1'b0;
		rows_reg   = vals[0][SIZE_W-1:0];
		cols_reg   = vals[1][SIZE_W-1:0];
		planes_reg = vals[2][SIZE_W-1:0];
		bad_reg    = vals[3];
	endtask

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	always @(posedge clk) begin : watch_results
		sample_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_samples.size() == 0) begin
				flag_mismatch($sformatf("result %0d outside=%0d with none pending",
					m_axis_tdata, m_axis_tuser));
			end else begin
				want = expected_samples.pop_front();
				if (m_axis_tdata !== want.value)
					flag_mismatch($sformatf("sample_value %0d, predicted %0d",
						m_axis_tdata, want.value));
				if (m_axis_tuser !== want.outside)
					flag_mismatch($sformatf("outside_flag %0d, predicted %0d",
						m_axis_tuser, want.outside));
			end
		end
	end

	initial begin : stimulus
		int  phase_end;
		int  pick;
		int  vol;
		bit  halfway_pause;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_SIZE_ROWS;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = MODE_LOAD;
		m_axis_tready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (probes[i]) begin
			if (probes[i].mode == MODE_LOAD)
				push_item(MODE_LOAD, probes[i].index, probes[i].voxel, probes[i].row,
					probes[i].col, probes[i].plane, 1'b0, '0);
			else
				request_sample(probes[i].row, probes[i].col, probes[i].plane,
					probes[i].typed, probes[i].want);
		end
		settle();

		for (int ph = 0; ph < PHASES; ph++) begin
			set_config(geometry_plan[ph]);
			phase_end     = items_sent + PHASE_ITEMS;
			halfway_pause = (ph == 2);
			while (items_sent < phase_end) begin
				if (halfway_pause && items_sent >= phase_end - PHASE_ITEMS / 2) begin
					settle();
					halfway_pause = 1'b0;
				end
				pick = $urandom_range(0, 99);
				vol  = extent(rows_reg) * extent(cols_reg) * extent(planes_reg);
				if (pick < 70) begin
					request_sample(pick_coord(extent(rows_reg)), pick_coord(extent(cols_reg)),
						pick_coord(extent(planes_reg)), 1'b0, '0);
				end else if (pick < 90 && vol > 0) begin
					push_item(MODE_LOAD, INDEX_W'($urandom_range(0, vol - 1)),
						VOXEL_W'($urandom()), coord_t'($urandom()), coord_t'($urandom()),
						coord_t'($urandom()), 1'b0, '0);
				end else begin
					push_item(MODE_LOAD, INDEX_W'($urandom()), VOXEL_W'($urandom()),
						coord_t'($urandom()), coord_t'($urandom()),
						coord_t'($urandom()), 1'b0, '0);
				end
			end
			settle();
		end

		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/tsv_pkg.sv
rtl/core/tsv_front.sv
rtl/core/tsv_fifo.sv
rtl/core/tsv_back.sv
rtl/core/trilinear_sample_uint8_volume.sv
tb/tb.sv
